// ===== hdl/ps_pkg.sv =====
// shared types and microcode codes for the pancake sorter
// no dependencies; imported by ps_sequencer and pancake_sorter_unit

package ps_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 5;
    localparam int COND_W = 4;
    localparam int STEP_W = 5;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [OP_W-1:0]          op_t;
    typedef logic [COND_W-1:0]        cond_t;
    typedef logic [STEP_W-1:0]        step_t;

    // datapath operations
    localparam op_t OP_NONE       = 5'd0;
    localparam op_t OP_LOAD       = 5'd1;
    localparam op_t OP_SETLEN     = 5'd2;
    localparam op_t OP_SCAN_INIT  = 5'd3;
    localparam op_t OP_SCAN_FIRST = 5'd4;
    localparam op_t OP_SCAN_RD    = 5'd5;
    localparam op_t OP_SCAN_CMP   = 5'd6;
    localparam op_t OP_FLIP1_SET  = 5'd7;
    localparam op_t OP_FLIP2_SET  = 5'd8;
    localparam op_t OP_SW_RD_LO   = 5'd9;
    localparam op_t OP_SW_RD_HI   = 5'd10;
    localparam op_t OP_SW_WR_LO   = 5'd11;
    localparam op_t OP_SW_WR_HI   = 5'd12;
    localparam op_t OP_SHRINK     = 5'd13;
    localparam op_t OP_EMIT_INIT  = 5'd14;
    localparam op_t OP_EMIT       = 5'd15;
    localparam op_t OP_DONE       = 5'd16;

    // jump conditions; a step jumps to its target when its condition holds
    localparam cond_t C_NEXT       = 4'd0;
    localparam cond_t C_ALWAYS     = 4'd1;
    localparam cond_t C_NOT_CLOSED = 4'd2;
    localparam cond_t C_LEN_LE1    = 4'd3;
    localparam cond_t C_IDX_LT_LEN = 4'd4;
    localparam cond_t C_MAX_AT_END = 4'd5;
    localparam cond_t C_MAX_ZERO   = 4'd6;
    localparam cond_t C_SWAP_MORE  = 4'd7;
    localparam cond_t C_EMIT_STAY  = 4'd8;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic set_closed;
        logic len_le1;
        logic idx_lt_len;
        logic max_at_end;
        logic max_zero;
        logic swap_more;
        logic emit_done;
    } status_t;

endpackage

// ===== hdl/ps_sequencer.sv =====
// microcode rom, step counter and jump logic for the pancake sorter
// depends on ps_pkg

module ps_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  ps_pkg::status_t status,
    output ps_pkg::ucode_t  uword
);
    import ps_pkg::*;

    localparam step_t S_IDLE      = 5'd0;
    localparam step_t S_SETLEN    = 5'd1;
    localparam step_t S_PASS      = 5'd2;
    localparam step_t S_SCAN_INIT = 5'd3;
    localparam step_t S_SCAN_1ST  = 5'd4;
    localparam step_t S_SCAN_RD   = 5'd5;
    localparam step_t S_SCAN_CMP  = 5'd6;
    localparam step_t S_CHECK     = 5'd7;
    localparam step_t S_FLIP1     = 5'd8;
    localparam step_t S_F1_RD_LO  = 5'd9;
    localparam step_t S_F1_RD_HI  = 5'd10;
    localparam step_t S_F1_WR_LO  = 5'd11;
    localparam step_t S_F1_WR_HI  = 5'd12;
    localparam step_t S_FLIP2     = 5'd13;
    localparam step_t S_F2_RD_LO  = 5'd14;
    localparam step_t S_F2_RD_HI  = 5'd15;
    localparam step_t S_F2_WR_LO  = 5'd16;
    localparam step_t S_F2_WR_HI  = 5'd17;
    localparam step_t S_SHRINK    = 5'd18;
    localparam step_t S_EMIT_INIT = 5'd19;
    localparam step_t S_EMIT      = 5'd20;
    localparam step_t S_DONE      = 5'd21;

    function automatic ucode_t rom(input step_t s);
        ucode_t w;
        begin
            unique case (s)
                S_IDLE:      w = '{OP_LOAD,       C_NOT_CLOSED, S_IDLE};
                S_SETLEN:    w = '{OP_SETLEN,     C_NEXT,       S_IDLE};
                S_PASS:      w = '{OP_NONE,       C_LEN_LE1,    S_EMIT_INIT};
                S_SCAN_INIT: w = '{OP_SCAN_INIT,  C_NEXT,       S_IDLE};
                S_SCAN_1ST:  w = '{OP_SCAN_FIRST, C_NEXT,       S_IDLE};
                S_SCAN_RD:   w = '{OP_SCAN_RD,    C_NEXT,       S_IDLE};
                S_SCAN_CMP:  w = '{OP_SCAN_CMP,   C_IDX_LT_LEN, S_SCAN_RD};
                S_CHECK:     w = '{OP_NONE,       C_MAX_AT_END, S_SHRINK};
                S_FLIP1:     w = '{OP_FLIP1_SET,  C_MAX_ZERO,   S_FLIP2};
                S_F1_RD_LO:  w = '{OP_SW_RD_LO,   C_NEXT,       S_IDLE};
                S_F1_RD_HI:  w = '{OP_SW_RD_HI,   C_NEXT,       S_IDLE};
                S_F1_WR_LO:  w = '{OP_SW_WR_LO,   C_NEXT,       S_IDLE};
                S_F1_WR_HI:  w = '{OP_SW_WR_HI,   C_SWAP_MORE,  S_F1_RD_LO};
                S_FLIP2:     w = '{OP_FLIP2_SET,  C_NEXT,       S_IDLE};
                S_F2_RD_LO:  w = '{OP_SW_RD_LO,   C_NEXT,       S_IDLE};
                S_F2_RD_HI:  w = '{OP_SW_RD_HI,   C_NEXT,       S_IDLE};
                S_F2_WR_LO:  w = '{OP_SW_WR_LO,   C_NEXT,       S_IDLE};
                S_F2_WR_HI:  w = '{OP_SW_WR_HI,   C_SWAP_MORE,  S_F2_RD_LO};
                S_SHRINK:    w = '{OP_SHRINK,     C_ALWAYS,     S_PASS};
                S_EMIT_INIT: w = '{OP_EMIT_INIT,  C_NEXT,       S_IDLE};
                S_EMIT:      w = '{OP_EMIT,       C_EMIT_STAY,  S_EMIT};
                S_DONE:      w = '{OP_DONE,       C_ALWAYS,     S_IDLE};
                default:     w = '{OP_NONE,       C_ALWAYS,     S_IDLE};
            endcase
            return w;
        end
    endfunction

    step_t pc_reg;
    step_t pc_next;
    logic  jump;

    assign uword = rom(pc_reg);

    always_comb
    begin
        unique case (uword.cond)
            C_NEXT:       jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_NOT_CLOSED: jump = !status.set_closed;
            C_LEN_LE1:    jump = status.len_le1;
            C_IDX_LT_LEN: jump = status.idx_lt_len;
            C_MAX_AT_END: jump = status.max_at_end;
            C_MAX_ZERO:   jump = status.max_zero;
            C_SWAP_MORE:  jump = status.swap_more;
            C_EMIT_STAY:  jump = !status.emit_done;
            default:      jump = 1'b1;
        endcase
        pc_next = jump ? uword.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hdl/pancake_sorter_unit.sv =====
// pancake sorter top level: value buffer, datapath and output register
// depends on ps_pkg and ps_sequencer
// load: one word per cycle until tlast; sort of n words: n-1 passes, each a max scan of the
// unsorted prefix plus the swaps of each flip (read lo, read hi, write lo, write hi)
// emit: n words at one per cycle while the receiver is ready, after a registered read of word 0
// reset (async, active low) returns to loading with an empty buffer, no clearing pass

module pancake_sorter_unit #(
    parameter int CAPACITY = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  ps_pkg::data_t s_axis_tdata,   // [31:0] element_value
    input  logic          s_axis_tlast,   // end_of_set
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output ps_pkg::data_t m_axis_tdata,   // [31:0] sorted_value
    output logic          m_axis_tlast    // final_value
);
    import ps_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] cnt_t;

    ucode_t  uword;
    status_t status;

    ps_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uword  (uword)
    );

    // value buffer, one write and one registered read per cycle
    data_t mem [CAPACITY];
    data_t rd_data_reg;
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    data_t wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    cnt_t  count_reg, count_next;     // words held
    cnt_t  len_reg, len_next;         // unsorted prefix length
    cnt_t  idx_reg, idx_next;         // scan or emit position
    addr_t maxpos_reg, maxpos_next;   // first maximum of the prefix
    addr_t lo_reg, lo_next;           // flip ends
    addr_t hi_reg, hi_next;
    logic  m_valid_reg, m_valid_next;

    // payload registers
    data_t maxval_reg, maxval_next;
    data_t tmp_reg, tmp_next;
    data_t m_data_reg, m_data_next;
    logic  m_last_reg, m_last_next;

    logic  in_accept;
    logic  out_free;
    cnt_t  idx_inc;
    cnt_t  len_dec;
    logic [AW:0] lo_plus2;

    assign s_axis_tready = (uword.op == OP_LOAD);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign idx_inc       = idx_reg + 1'b1;
    assign len_dec       = len_reg - 1'b1;
    assign lo_plus2      = {1'b0, lo_reg} + (AW+1)'(2);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // flags for the jump logic
    always_comb
    begin
        status.set_closed = in_accept && s_axis_tlast;
        status.len_le1    = (len_reg <= cnt_t'(1));
        status.idx_lt_len = (idx_inc < len_reg);
        status.max_at_end = (cnt_t'(maxpos_reg) == len_dec);
        status.max_zero   = (maxpos_reg == '0);
        // another swap remains when lo+1 < hi-1
        status.swap_more  = (lo_plus2 < {1'b0, hi_reg});
        status.emit_done  = out_free && (idx_inc == count_reg);
    end

    always_comb
    begin
        count_next   = count_reg;
        len_next     = len_reg;
        idx_next     = idx_reg;
        maxpos_next  = maxpos_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        maxval_next  = maxval_reg;
        tmp_next     = tmp_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = s_axis_tdata;

        // output register drains on its own
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (uword.op)
            OP_LOAD:
            begin
                // a word beyond capacity is dropped, its tlast still closes the set
                if (in_accept && (count_reg < cnt_t'(CAPACITY)))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[AW-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            OP_SETLEN:
            begin
                len_next = count_reg;
            end
            OP_SCAN_INIT:
            begin
                rd_en       = 1'b1;
                rd_addr     = '0;
                idx_next    = cnt_t'(1);
                maxpos_next = '0;
            end
            OP_SCAN_FIRST:
            begin
                maxval_next = rd_data_reg;
            end
            OP_SCAN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[AW-1:0];
            end
            OP_SCAN_CMP:
            begin
                // strict compare keeps the first maximum
                if (rd_data_reg > maxval_reg)
                begin
                    maxval_next = rd_data_reg;
                    maxpos_next = idx_reg[AW-1:0];
                end
                idx_next = idx_inc;
            end
            OP_FLIP1_SET:
            begin
                lo_next = '0;
                hi_next = maxpos_reg;
            end
            OP_FLIP2_SET:
            begin
                lo_next = '0;
                hi_next = len_dec[AW-1:0];
            end
            OP_SW_RD_LO:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_reg;
            end
            OP_SW_RD_HI:
            begin
                rd_en    = 1'b1;
                rd_addr  = hi_reg;
                tmp_next = rd_data_reg;
            end
            OP_SW_WR_LO:
            begin
                wr_en   = 1'b1;
                wr_addr = lo_reg;
                wr_data = rd_data_reg;
            end
            OP_SW_WR_HI:
            begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = tmp_reg;
                lo_next = lo_reg + 1'b1;
                hi_next = hi_reg - 1'b1;
            end
            OP_SHRINK:
            begin
                len_next = len_dec;
            end
            OP_EMIT_INIT:
            begin
                rd_en    = 1'b1;
                rd_addr  = '0;
                idx_next = '0;
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = rd_data_reg;
                    m_last_next  = (idx_inc == count_reg);
                    idx_next     = idx_inc;
                    rd_en        = 1'b1;
                    rd_addr      = idx_inc[AW-1:0];
                end
            end
            OP_DONE:
            begin
                count_next = '0;
                len_next   = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            len_reg     <= '0;
            idx_reg     <= '0;
            maxpos_reg  <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            len_reg     <= len_next;
            idx_reg     <= idx_next;
            maxpos_reg  <= maxpos_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        maxval_reg <= maxval_next;
        tmp_reg    <= tmp_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

endmodule

// ===== test/pancake_sorter_unit_tb.sv =====
// self-checking testbench for pancake_sorter_unit: random and directed sets of signed words
// depends on ps_pkg and the pancake_sorter_unit rtl; runs alone, no files or arguments

module pancake_sorter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ps_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int HOLD_CYCLES    = 3000;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 200000;  // cycles with no word moving on either side
    localparam int TAIL_CYCLES    = 50;      // settle time once nothing is expected
    localparam int PHASE_WORDS    = 60;      // random words per idling phase, at least

    // one input word as it travels on the slave side
    typedef struct packed {
        data_t value;
        logic  last;
    } set_word_t;

    // one expected output word
    typedef struct packed {
        data_t value;
        logic  last;
    } sorted_word_t;

    logic  clk           = 1'b0;
    logic  rst_n         = 1'b0;
    logic  s_axis_tvalid = 1'b0;
    logic  s_axis_tready;
    data_t s_axis_tdata  = '0;     // [31:0] element_value
    logic  s_axis_tlast  = 1'b0;   // end_of_set
    logic  m_axis_tvalid;
    logic  m_axis_tready = 1'b0;
    data_t m_axis_tdata;           // [31:0] sorted_value
    logic  m_axis_tlast;           // final_value

    pancake_sorter_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // words waiting to go in, sorted words waiting to come out
    set_word_t    pending_words[$];
    sorted_word_t sorted_expect[$];

    // predictor state: the set collected so far
    data_t held_values[CAPACITY];
    int    held_count = 0;

    // idling controls; stimulus sets the percentages and hold_arm at falling edges only
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_arm = 1'b0;
    logic hold_started = 1'b0;
    int   hold_left = 0;

    // run statistics
    int mismatches    = 0;
    int words_queued  = 0;
    int words_taken   = 0;
    int sets_closed   = 0;
    int words_checked = 0;
    int largest_set   = 0;
    int idle_cycles   = 0;

    // reverse held_values[0..top]
    task automatic flip_prefix(int top);
        int    lo;
        int    hi;
        data_t tmp;
        lo = 0;
        hi = top;
        while (lo < hi) begin
            tmp             = held_values[lo];
            held_values[lo] = held_values[hi];
            held_values[hi] = tmp;
            lo++;
            hi--;
        end
    endtask

    // predictor: store one accepted word; a closing word sorts the set and queues its output
    task automatic take_set_word(data_t value, logic last);
        int unsorted;
        int top;
        int i;
        // words past the capacity are dropped, but a closing one still closes the set
        if (held_count < CAPACITY) begin
            held_values[held_count] = value;
            held_count++;
        end
        if (last) begin
            unsorted = held_count;
            while (unsorted > 1) begin
                // first maximum of the unsorted prefix
                top = 0;
                for (i = 1; i < unsorted; i++) begin
                    if (held_values[i] > held_values[top]) top = i;
                end
                // a maximum already at the end of the prefix needs no flips
                if (top != unsorted - 1) begin
                    if (top != 0) flip_prefix(top);
                    flip_prefix(unsorted - 1);
                end
                unsorted--;
            end
            for (i = 0; i < held_count; i++) begin
                sorted_expect.push_back('{value: held_values[i], last: (i == held_count - 1)});
            end
            if (held_count > largest_set) largest_set = held_count;
            sets_closed++;
            held_count = 0;
        end
    endtask

    task automatic queue_word(data_t value, logic last);
        pending_words.push_back('{value: value, last: last});
        words_queued++;
    endtask

    // one closed set of random content; styles give wide values, many duplicates,
    // the extremes, and monotonic runs either way
    task automatic queue_random_set(int size);
        int    style;
        int    i;
        data_t v;
        data_t base;
        logic  up;
        style = $urandom_range(0, 3);
        base  = $urandom;
        up    = 1'($urandom_range(0, 1));
        for (i = 0; i < size; i++) begin
            case (style)
                0: v = $urandom;
                1:
                begin
                    v = $urandom_range(0, 6);
                    v = v - 3;
                end
                2:
                begin
                    case ($urandom_range(0, 4))
                        0: v = 32'sh7fffffff;
                        1: v = 32'sh80000000;
                        2: v = '0;
                        3: v = -1;
                        default: v = $urandom;
                    endcase
                end
                default: v = up ? base + i : base - i;
            endcase
            queue_word(v, i == size - 1);
        end
    endtask

    // mostly small sets, now and then a near-full, full or overfull one
    function automatic int pick_set_size();
        if ($urandom_range(0, 24) == 0) return $urandom_range(CAPACITY - 4, CAPACITY + 8);
        return $urandom_range(1, 14);
    endfunction

    // driver: presents the head of pending_words; valid stays up until the word is taken
    always @(posedge clk or negedge rst_n)
    begin : drive_words
        logic holding;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else begin
            holding = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                take_set_word(s_axis_tdata, s_axis_tlast);
                void'(pending_words.pop_front());
                words_taken++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_words[0].value;
                    s_axis_tlast  <= pending_words[0].last;
                end
                else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here so the monitor only looks at hold_left
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_left    <= 0;
            hold_started <= 1'b0;
        end
        else if (hold_arm && !hold_started) begin
            hold_left    <= HOLD_CYCLES;
            hold_started <= 1'b1;
        end
        else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: checks every taken output word against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : check_words
        sorted_word_t head;
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (sorted_expect.size() == 0) begin
                    $error("unexpected sorted word: sorted_value %0d final_value %0b",
                           m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else begin
                    head = sorted_expect.pop_front();
                    if (m_axis_tdata !== head.value) begin
                        $error("sorted_value: expected %0d, actual %0d", head.value, m_axis_tdata);
                        mismatches++;
                    end
                    if (m_axis_tlast !== head.last) begin
                        $error("final_value: expected %0b, actual %0b", head.last, m_axis_tlast);
                        mismatches++;
                    end
                end
                words_checked++;
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog: too long with no word moving on either side ends the run
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: %0d cycles with no progress, %0d words still expected",
                         idle_cycles, sorted_expect.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // stimulus and phase control; all changes happen at falling edges
    initial
    begin : stimulus
        int send_pcts[4];
        int recv_pcts[4];
        int mode;
        int phase_start;
        int i;
        send_pcts = '{0, 68, 0, 34};
        recv_pcts = '{0, 0, 68, 34};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: single-word sets at both extremes
        queue_word(32'sh7fffffff, 1'b1);
        queue_word(32'sh80000000, 1'b1);
        // extremes, zero, minus one and a repeated maximum in one set
        queue_word(32'sh7fffffff, 1'b0);
        queue_word(32'sh80000000, 1'b0);
        queue_word(-1, 1'b0);
        queue_word('0, 1'b0);
        queue_word(32'sh7fffffff, 1'b1);
        // already ascending: every pass finds its maximum at the end
        for (i = 0; i < 4; i++) queue_word(i - 2, i == 3);
        // descending: the first pass finds its maximum first and needs only one flip
        for (i = 0; i < 4; i++) queue_word(1000 - i * 300, i == 3);
        // all equal
        for (i = 0; i < 3; i++) queue_word(32'sh12345678, i == 2);
        // pair out of order
        queue_word(5, 1'b0);
        queue_word(-5, 1'b1);

        while (pending_words.size() > 0 || sorted_expect.size() > 0) @(negedge clk);

        // random phases, each one draining fully before the next idling pattern
        for (mode = 0; mode < 4; mode++) begin
            send_idle_pct  = send_pcts[mode];
            recv_stall_pct = recv_pcts[mode];
            phase_start    = words_queued;
            while (words_queued - phase_start < PHASE_WORDS) queue_random_set(pick_set_size());
            while (pending_words.size() > 0 || sorted_expect.size() > 0) @(negedge clk);
        end

        // pressure: receiver held off while sets keep coming, so the input stalls;
        // includes a set that fills the buffer exactly and one that overflows it
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_arm       = 1'b1;
        for (i = 0; i < 6; i++) queue_random_set($urandom_range(1, 10));
        queue_random_set(CAPACITY);
        queue_random_set(CAPACITY + 6);
        queue_random_set($urandom_range(1, 10));
        while (pending_words.size() > 0 || sorted_expect.size() > 0) @(negedge clk);

        repeat (TAIL_CYCLES) @(negedge clk);
        if (sorted_expect.size() != 0) begin
            $error("%0d sorted words never arrived", sorted_expect.size());
            mismatches++;
        end

        $display("run covered %0d input words in %0d sets (largest held %0d), %0d output words",
                 words_taken, sets_closed, largest_set, words_checked);
        $display("idling phases: none, sender, receiver, both, plus a %0d-cycle receiver hold",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end
        else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
